// File: hw/rtl/n2a_pkg.sv
// Shared types, command codes and digit helpers for the number-to-ASCII formatter.
// Used by n2a_conv, n2a_ser and number_to_ascii_formatter; depends on nothing.
`default_nettype none

package n2a_pkg;

  // Command codes
  localparam logic [1:0] CMD_HEX_BYTE  = 2'd0;
  localparam logic [1:0] CMD_HEX_SHORT = 2'd1;
  localparam logic [1:0] CMD_DECIMAL   = 2'd2;
  localparam logic [1:0] CMD_RAW_SHORT = 2'd3;

  localparam int unsigned MaxBytes = 5;
  localparam int unsigned IdxW     = $clog2(MaxBytes);

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A    = 8'h41;

  // Input item
  typedef struct packed {
    logic [15:0] value;
    logic [1:0]  command;
  } in_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // Formatted run handed from the converter to the serializer
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]          last_idx;
  } fmt_t;

  // One decimal digit and what is left below its weight
  typedef struct packed {
    logic [3:0]  digit;
    logic [15:0] rem;
  } dig_t;

  // Uppercase hex character of a nibble
  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = ASCII_ZERO + {4'd0, n};
    end else begin
      c = ASCII_A + {4'd0, n} - 8'd10;
    end
    return c;
  endfunction

  // Leading decimal digit of r for a constant weight, by parallel compares
  // against the multiples of the weight; r must be below ten times the weight.
  function automatic dig_t digit_step(input logic [15:0] r, input logic [13:0] weight);
    dig_t       res;
    logic [17:0] thr;
    res.digit = 4'd0;
    res.rem   = r;
    for (int k = 1; k < 10; k++) begin
      thr = 18'(k) * {4'd0, weight};
      if ({2'd0, r} >= thr) begin
        res.digit = 4'(k);
        res.rem   = 16'({2'd0, r} - thr);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/number_to_ascii_formatter.sv
// Number-to-ASCII formatter: 16-bit value plus command in, one byte per
// output transfer, final byte of each run flagged with last.
// Commands: hex byte (2 bytes), hex short (4), five-digit decimal (5),
// raw short (2), always most significant first.
// Input channel in_valid_i/in_ready_o/in_data_i, output channel
// out_valid_o/out_ready_i/out_data_o, both valid/ready.
// The first byte of a run passes the three converter stages and then the
// serializer buffer before it is valid on the output.
// The serializer sends one byte per transfer, one per cycle while the
// receiver is ready; the next run is loaded in the cycle the final byte of
// the current one transfers, so output runs go back to back.
// The converter stages keep taking items while the serializer works, until
// they fill up.
// Reset clears all valid bits and the serializer byte index; nothing else is held.
// When the receiver stalls, the current byte holds and the stall backs up
// through the stages without losing or repeating an item.
`default_nettype none

module number_to_ascii_formatter
  import n2a_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic fmt_valid;
  logic fmt_ready;
  fmt_t fmt;

  n2a_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fmt_valid_o (fmt_valid),
    .fmt_ready_i (fmt_ready),
    .fmt_o       (fmt)
  );

  n2a_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_valid_i (fmt_valid),
    .fmt_ready_o (fmt_ready),
    .fmt_i       (fmt),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/n2a_conv.sv
// Three-stage converter: decimal digit extraction and character formatting.
// Depends on n2a_pkg.
`default_nettype none

module n2a_conv
  import n2a_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      fmt_valid_o,
  input  wire logic fmt_ready_i,
  output fmt_t      fmt_o
);

  // Stage 1: ten-thousands digit
  logic        vld1_q;
  logic [15:0] val1_q;
  logic [1:0]  cmd1_q;
  logic [3:0]  d4_1_q;
  logic [13:0] rem1_q;
  // Stage 2: thousands and hundreds digits
  logic        vld2_q;
  logic [15:0] val2_q;
  logic [1:0]  cmd2_q;
  logic [3:0]  d4_2_q, d3_2_q, d2_2_q;
  logic [6:0]  rem2_q;
  // Stage 3: formatted bytes
  logic        vld3_q;
  fmt_t        fmt3_q;

  logic rdy1, rdy2, rdy3;
  dig_t s1_d4, s2_d3, s2_d2, s3_d1, s3_d0;
  fmt_t fmt3_d;

  // Stall chain: a stage takes data when it is empty or its contents move on
  assign rdy3       = !vld3_q || fmt_ready_i;
  assign rdy2       = !vld2_q || rdy3;
  assign rdy1       = !vld1_q || rdy2;
  assign in_ready_o = rdy1;

  assign s1_d4 = digit_step(in_data_i.value, 14'd10000);
  assign s2_d3 = digit_step({2'd0, rem1_q}, 14'd1000);
  assign s2_d2 = digit_step(s2_d3.rem, 14'd100);
  assign s3_d1 = digit_step({9'd0, rem2_q}, 14'd10);
  assign s3_d0 = digit_step(s3_d1.rem, 14'd1);

  // Byte run per command, first byte out in slot 0
  always_comb begin
    fmt3_d = '0;
    case (cmd2_q)
      CMD_HEX_BYTE: begin
        fmt3_d.bytes[0] = nibble_char(val2_q[7:4]);
        fmt3_d.bytes[1] = nibble_char(val2_q[3:0]);
        fmt3_d.last_idx = IdxW'(1);
      end
      CMD_HEX_SHORT: begin
        fmt3_d.bytes[0] = nibble_char(val2_q[15:12]);
        fmt3_d.bytes[1] = nibble_char(val2_q[11:8]);
        fmt3_d.bytes[2] = nibble_char(val2_q[7:4]);
        fmt3_d.bytes[3] = nibble_char(val2_q[3:0]);
        fmt3_d.last_idx = IdxW'(3);
      end
      CMD_DECIMAL: begin
        fmt3_d.bytes[0] = nibble_char(d4_2_q);
        fmt3_d.bytes[1] = nibble_char(d3_2_q);
        fmt3_d.bytes[2] = nibble_char(d2_2_q);
        fmt3_d.bytes[3] = nibble_char(s3_d1.digit);
        fmt3_d.bytes[4] = nibble_char(s3_d0.digit);
        fmt3_d.last_idx = IdxW'(4);
      end
      CMD_RAW_SHORT: begin
        fmt3_d.bytes[0] = val2_q[15:8];
        fmt3_d.bytes[1] = val2_q[7:0];
        fmt3_d.last_idx = IdxW'(1);
      end
      default: begin
        fmt3_d = '0;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= in_valid_i;
      if (rdy2) vld2_q <= vld1_q;
      if (rdy3) vld3_q <= vld2_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      val1_q <= in_data_i.value;
      cmd1_q <= in_data_i.command;
      d4_1_q <= s1_d4.digit;
      rem1_q <= s1_d4.rem[13:0];
    end
    if (rdy2 && vld1_q) begin
      val2_q <= val1_q;
      cmd2_q <= cmd1_q;
      d4_2_q <= d4_1_q;
      d3_2_q <= s2_d3.digit;
      d2_2_q <= s2_d2.digit;
      rem2_q <= s2_d2.rem[6:0];
    end
    if (rdy3 && vld2_q) begin
      fmt3_q <= fmt3_d;
    end
  end

  assign fmt_valid_o = vld3_q;
  assign fmt_o       = fmt3_q;

endmodule

`default_nettype wire

// File: hw/rtl/n2a_ser.sv
// Serializer: holds one formatted run and sends it one byte per transfer.
// Depends on n2a_pkg.
`default_nettype none

module n2a_ser
  import n2a_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fmt_valid_i,
  output logic      fmt_ready_o,
  input  wire fmt_t fmt_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  logic                     vld_q;
  logic [MaxBytes-1:0][7:0] buf_q;
  logic [IdxW-1:0]          last_idx_q;
  logic [IdxW-1:0]          idx_q;
  logic                     at_last;
  logic                     out_xfer;
  logic                     load;

  assign at_last     = (idx_q == last_idx_q);
  assign out_xfer    = vld_q && out_ready_i;
  // Next run loads while the final byte of this one leaves
  assign fmt_ready_o = !vld_q || (out_ready_i && at_last);
  assign load        = fmt_ready_o && fmt_valid_i;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (out_xfer) begin
      if (at_last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Run buffer
  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q      <= fmt_i.bytes;
      last_idx_q <= fmt_i.last_idx;
    end
  end

  // Byte select
  always_comb begin
    out_data_o.last = at_last;
    case (idx_q)
      IdxW'(0): out_data_o.out_byte = buf_q[0];
      IdxW'(1): out_data_o.out_byte = buf_q[1];
      IdxW'(2): out_data_o.out_byte = buf_q[2];
      IdxW'(3): out_data_o.out_byte = buf_q[3];
      IdxW'(4): out_data_o.out_byte = buf_q[4];
      default:  out_data_o.out_byte = buf_q[0];
    endcase
  end

  assign out_valid_o = vld_q;

endmodule

`default_nettype wire
